>>> hw/rtl/wtf8_to_utf16_decoder_assert.svh
// Assertion macros for the WTF-8 to UTF-16 decoder.
// No dependencies; included by the files that check their own logic.
`ifndef WTF8_TO_UTF16_DECODER_ASSERT_SVH
`define WTF8_TO_UTF16_DECODER_ASSERT_SVH

`ifndef SYNTHESIS
// Property holds at every clock edge outside reset.
`define W8U16_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("%m: assertion failed");
// Consequence holds in the cycle after the antecedent.
`define W8U16_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("%m: assertion failed");
`else
`define W8U16_ASSERT(lbl, clk, rstn, prop)
`define W8U16_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

>>> hw/rtl/w8u16_pkg.sv
// Types and constants of the WTF-8 to UTF-16 decoder.
// No dependencies; imported by wtf8_to_utf16_decoder and its bench.
package w8u16_pkg;

    localparam logic [7:0]  LEAD_MIN   = 8'hC2;
    localparam logic [7:0]  LEAD2_MAX  = 8'hDF;
    localparam logic [7:0]  LEAD3_MAX  = 8'hEF;
    localparam logic [7:0]  LEAD4_MAX  = 8'hF4;
    localparam logic [7:0]  ASCII_LIM  = 8'h80;
    localparam logic [20:0] CP_MAX     = 21'h10FFFF;
    localparam logic [20:0] SUPP_BASE  = 21'h010000;
    localparam logic [15:0] HI_SURR    = 16'hD800;
    localparam logic [15:0] LO_SURR    = 16'hDC00;
    localparam logic [15:0] SURR_MASK  = 16'h03FF;

    // Continuation bytes still expected
    localparam logic [1:0]  PEND_IDLE  = 2'd0;
    localparam logic [1:0]  PEND_ONE   = 2'd1;
    localparam logic [1:0]  PEND_TWO   = 2'd2;
    localparam logic [1:0]  PEND_THREE = 2'd3;

    // Result buffer: room for a surrogate pair behind two waiting units
    localparam int          QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        run_last;
        logic        bad_sequence;
        logic        string_end;
    } result_t;

endpackage

>>> hw/rtl/wtf8_to_utf16_decoder.sv
// WTF-8 to UTF-16 decoder, top level.
// Depends on w8u16_pkg and wtf8_to_utf16_decoder_assert.svh.
//
// Usage:
//   Input channel (s_valid, s_ready, s_in_byte) takes one byte of a
//   zero-terminated WTF-8 string per beat. Result channel (m_valid,
//   m_ready, m_code_unit, m_run_last, m_bad_sequence, m_string_end)
//   gives one UTF-16 code unit per beat.
//   A byte is decoded in the cycle it is accepted; its results are
//   registered into the result buffer. A byte can be taken every cycle
//   while s_ready is high. A value above 0xFFFF leaves as two beats (high
//   then low surrogate), but it takes four bytes, so a receiver that takes
//   a beat every cycle never holds back the input.
//   Results wait in a four-entry result buffer; s_ready is high while at
//   most two results wait, so a stalled receiver holds the input once
//   more than two results wait, and no result is ever dropped.
//   On an invalid sequence one beat with bad_sequence set is given, and
//   bytes are dropped up to the zero terminator, which always yields a
//   beat with string_end set.
//   Reset (aresetn low at a clock edge) empties the result buffer and
//   returns the decoder to the start of a string.
`include "wtf8_to_utf16_decoder_assert.svh"

module wtf8_to_utf16_decoder
    import w8u16_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_code_unit,
    output logic        m_run_last,
    output logic        m_bad_sequence,
    output logic        m_string_end
);

    logic [1:0]  pending_reg, pending_next;
    logic [20:0] partial_reg, partial_next;
    logic [7:0]  lead_reg, lead_next;
    logic        discarding_reg, discarding_next;

    result_t     q_reg [QUEUE_DEPTH];
    result_t     q_next [QUEUE_DEPTH];
    logic [2:0]  cnt_reg, cnt_next;

    logic        accept;
    logic        pop;
    logic [1:0]  n_res;
    result_t     res0, res1;
    logic [20:0] shifted;
    logic [20:0] cp;
    logic [20:0] supp;
    logic [2:0]  cnt_after;

    assign accept  = s_valid && s_ready;
    assign s_ready = (cnt_reg <= 3'd2);
    assign m_valid = (cnt_reg != 3'd0);
    assign pop     = m_valid && m_ready;

    assign m_code_unit    = q_reg[0].code_unit;
    assign m_run_last     = q_reg[0].run_last;
    assign m_bad_sequence = q_reg[0].bad_sequence;
    assign m_string_end   = q_reg[0].string_end;

    // Decode one byte
    always_comb begin
        pending_next    = pending_reg;
        partial_next    = partial_reg;
        lead_next       = lead_reg;
        discarding_next = discarding_reg;
        n_res           = 2'd0;
        res0            = '0;
        res1            = '0;
        shifted         = {partial_reg[14:0], s_in_byte[5:0]};
        cp              = '0;
        supp            = '0;

        if (accept) begin
            if (discarding_reg) begin
                if (s_in_byte == 8'h00) begin
                    discarding_next = 1'b0;
                    res0            = '{code_unit: 16'h0000, run_last: 1'b1,
                                        bad_sequence: 1'b0, string_end: 1'b1};
                    n_res           = 2'd1;
                end
            end else if (pending_reg == PEND_IDLE) begin
                if (s_in_byte == 8'h00) begin
                    res0  = '{code_unit: 16'h0000, run_last: 1'b1,
                              bad_sequence: 1'b0, string_end: 1'b1};
                    n_res = 2'd1;
                end else if (s_in_byte < ASCII_LIM) begin
                    res0  = '{code_unit: {8'h00, s_in_byte}, run_last: 1'b1,
                              bad_sequence: 1'b0, string_end: 1'b0};
                    n_res = 2'd1;
                end else if (s_in_byte < LEAD_MIN) begin
                    // stray continuation or overlong lead: flag and drop to the terminator
                    discarding_next = 1'b1;
                    partial_next    = '0;
                    lead_next       = '0;
                    res0            = '{code_unit: 16'h0000, run_last: 1'b1,
                                        bad_sequence: 1'b1, string_end: 1'b0};
                    n_res           = 2'd1;
                end else begin
                    lead_next    = s_in_byte;
                    partial_next = {13'd0, s_in_byte};
                    if (s_in_byte <= LEAD2_MAX) begin
                        pending_next = PEND_ONE;
                    end else if (s_in_byte <= LEAD3_MAX) begin
                        pending_next = PEND_TWO;
                    end else begin
                        pending_next = PEND_THREE;
                    end
                end
            end else if (s_in_byte[7:6] != 2'b10) begin
                // bad continuation; a zero here also closes the string
                pending_next = PEND_IDLE;
                partial_next = '0;
                lead_next    = '0;
                res0.bad_sequence = 1'b1;
                if (s_in_byte == 8'h00) begin
                    discarding_next = 1'b0;
                    res0.run_last   = 1'b0;
                    res1            = '{code_unit: 16'h0000, run_last: 1'b1,
                                        bad_sequence: 1'b0, string_end: 1'b1};
                    n_res           = 2'd2;
                end else begin
                    discarding_next = 1'b1;
                    res0.run_last   = 1'b1;
                    n_res           = 2'd1;
                end
            end else begin
                pending_next = pending_reg - 2'd1;
                if (pending_reg != PEND_ONE) begin
                    partial_next = shifted;
                end else begin
                    partial_next = '0;
                    lead_next    = '0;
                    if (lead_reg <= LEAD2_MAX) begin
                        cp = {10'd0, shifted[10:0]};
                    end else if (lead_reg <= LEAD3_MAX) begin
                        cp = {5'd0, shifted[15:0]};
                    end else begin
                        cp = shifted;
                    end
                    supp = cp - SUPP_BASE;
                    if (lead_reg > LEAD3_MAX &&
                        (lead_reg > LEAD4_MAX || shifted > CP_MAX)) begin
                        discarding_next = 1'b1;
                        res0            = '{code_unit: 16'h0000, run_last: 1'b1,
                                            bad_sequence: 1'b1, string_end: 1'b0};
                        n_res           = 2'd1;
                    end else if (cp[20:16] != 5'd0) begin
                        // emit high then low surrogate
                        res0  = '{code_unit: HI_SURR + {6'd0, supp[19:10]},
                                  run_last: 1'b0, bad_sequence: 1'b0,
                                  string_end: 1'b0};
                        res1  = '{code_unit: LO_SURR | (supp[15:0] & SURR_MASK),
                                  run_last: 1'b1, bad_sequence: 1'b0,
                                  string_end: 1'b0};
                        n_res = 2'd2;
                    end else begin
                        res0  = '{code_unit: cp[15:0], run_last: 1'b1,
                                  bad_sequence: 1'b0, string_end: 1'b0};
                        n_res = 2'd1;
                    end
                end
            end
        end
    end

    // Result buffer: advance on pop, append new results behind the survivors
    always_comb begin
        q_next    = q_reg;
        cnt_after = cnt_reg - {2'b00, pop};
        if (pop) begin
            q_next[0] = q_reg[1];
            q_next[1] = q_reg[2];
            q_next[2] = q_reg[3];
        end
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (n_res != 2'd0 && 3'(i) == cnt_after) begin
                q_next[i] = res0;
            end
            if (n_res == 2'd2 && 3'(i) == 3'(cnt_after + 3'd1)) begin
                q_next[i] = res1;
            end
        end
        cnt_next = cnt_after + {1'b0, n_res};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg    <= PEND_IDLE;
            partial_reg    <= '0;
            lead_reg       <= '0;
            discarding_reg <= 1'b0;
            cnt_reg        <= 3'd0;
        end else begin
            pending_reg    <= pending_next;
            partial_reg    <= partial_next;
            lead_reg       <= lead_next;
            discarding_reg <= discarding_next;
            cnt_reg        <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        q_reg <= q_next;
    end

    `W8U16_ASSERT_NEXT(a_term_idle, aclk, aresetn, accept && s_in_byte == 8'h00,
        !discarding_reg && pending_reg == PEND_IDLE)
    `W8U16_ASSERT(a_bad_zero, aclk, aresetn,
        !(m_valid && m_bad_sequence) || m_code_unit == 16'h0000)
    `W8U16_ASSERT(a_pair_queued, aclk, aresetn,
        !(m_valid && !m_run_last && !m_bad_sequence) || cnt_reg >= 3'd2)
    `W8U16_ASSERT(a_open_seq, aclk, aresetn,
        pending_reg == PEND_IDLE || (lead_reg >= LEAD_MIN && !discarding_reg))

endmodule

>>> bench/wtf8_to_utf16_decoder_tb.sv
// Self-checking bench for wtf8_to_utf16_decoder: byte strings in, UTF-16 units out.
// A scoreboard class predicts every unit from the accepted bytes and checks them in order.
// Depends on w8u16_pkg and the wtf8_to_utf16_decoder RTL.
module wtf8_to_utf16_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import w8u16_pkg::*;

    class utf16_unit_board;
        result_t     due_units[$];
        int          failures = 0;
        logic [1:0]  conts_left = PEND_IDLE;
        logic [20:0] gathered = '0;
        logic [7:0]  opener = '0;
        logic        skipping = 1'b0;

        function void push(logic [15:0] cu, logic last, logic bad, logic closes);
            result_t r;
            r.code_unit    = cu;
            r.run_last     = last;
            r.bad_sequence = bad;
            r.string_end   = closes;
            due_units.push_back(r);
        endfunction

        // Bad sequence: flag it, then drop bytes up to the terminator (a bad zero closes the string at once).
        function void reject(logic [7:0] b);
            conts_left = PEND_IDLE;
            gathered   = '0;
            opener     = '0;
            if (b == 8'h00) begin
                skipping = 1'b0;
                push(16'h0000, 1'b0, 1'b1, 1'b0);
                push(16'h0000, 1'b1, 1'b0, 1'b1);
            end else begin
                skipping = 1'b1;
                push(16'h0000, 1'b1, 1'b1, 1'b0);
            end
        endfunction

        function void note_byte(logic [7:0] b);
            logic [20:0] cp;
            logic [20:0] v;
            if (skipping) begin
                if (b == 8'h00) begin
                    skipping = 1'b0;
                    push(16'h0000, 1'b1, 1'b0, 1'b1);
                end
                return;
            end
            if (conts_left == PEND_IDLE) begin
                if (b == 8'h00)
                    push(16'h0000, 1'b1, 1'b0, 1'b1);
                else if (b < ASCII_LIM)
                    push({8'h00, b}, 1'b1, 1'b0, 1'b0);
                else if (b < LEAD_MIN)
                    reject(b);
                else begin
                    opener     = b;
                    gathered   = {13'b0, b};
                    conts_left = (b <= LEAD2_MAX) ? PEND_ONE :
                                 (b <= LEAD3_MAX) ? PEND_TWO : PEND_THREE;
                end
                return;
            end
            if (b[7:6] != 2'b10) begin
                reject(b);
                return;
            end
            gathered   = {gathered[14:0], b[5:0]};
            conts_left = conts_left - 2'd1;
            if (conts_left != PEND_IDLE)
                return;
            if (opener <= LEAD2_MAX)
                cp = gathered & 21'h0007FF;
            else if (opener <= LEAD3_MAX)
                cp = gathered & 21'h00FFFF;
            else begin
                if (opener > LEAD4_MAX || gathered > CP_MAX) begin
                    reject(b);
                    return;
                end
                cp = gathered;
            end
            gathered = '0;
            opener   = '0;
            if (cp > 21'h00FFFF) begin
                v = cp - SUPP_BASE;
                push(HI_SURR + {6'b0, v[19:10]}, 1'b0, 1'b0, 1'b0);
                push(LO_SURR + ({6'b0, v[9:0]} & SURR_MASK), 1'b1, 1'b0, 1'b0);
            end else begin
                push(cp[15:0], 1'b1, 1'b0, 1'b0);
            end
        endfunction

        function void check_unit(result_t got);
            result_t want;
            if (due_units.size() == 0) begin
                $error("unexpected beat: code_unit %h bad %b end %b",
                       got.code_unit, got.bad_sequence, got.string_end);
                failures++;
                return;
            end
            want = due_units.pop_front();
            if (got.code_unit !== want.code_unit) begin
                $error("code_unit: expected %h, got %h", want.code_unit, got.code_unit);
                failures++;
            end
            if (got.run_last !== want.run_last) begin
                $error("run_last: expected %b, got %b", want.run_last, got.run_last);
                failures++;
            end
            if (got.bad_sequence !== want.bad_sequence) begin
                $error("bad_sequence: expected %b, got %b",
                       want.bad_sequence, got.bad_sequence);
                failures++;
            end
            if (got.string_end !== want.string_end) begin
                $error("string_end: expected %b, got %b", want.string_end, got.string_end);
                failures++;
            end
        endfunction

        function int outstanding();
            return due_units.size();
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_in_byte = 8'h00;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [15:0] m_code_unit;
    logic        m_run_last;
    logic        m_bad_sequence;
    logic        m_string_end;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int bytes_sent = 0;

    utf16_unit_board units = new();

    // A valid string with a surrogate, a pair and the max value, then the error cases.
    localparam logic [7:0] WARMUP [29] = '{
        8'h7F, 8'hC2, 8'h80, 8'hED, 8'hA0, 8'h80, 8'hF0, 8'h90, 8'h80, 8'h80,
        8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'h00,
        8'hC1, 8'hFF, 8'h00,
        8'hC2, 8'h41, 8'h00,
        8'hE0, 8'h80, 8'h00,
        8'hF4, 8'h90, 8'h80, 8'h80, 8'h00
    };

    wtf8_to_utf16_decoder uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_in_byte      (s_in_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_code_unit    (m_code_unit),
        .m_run_last     (m_run_last),
        .m_bad_sequence (m_bad_sequence),
        .m_string_end   (m_string_end)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            units.check_unit(result_t'({m_code_unit, m_run_last, m_bad_sequence,
                                        m_string_end}));
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_in_byte <= b;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        units.note_byte(b);
        bytes_sent++;
    endtask

    function automatic logic [7:0] cont_byte();
        logic [5:0] r;
        r = 6'($urandom_range(63));
        return {2'b10, r};
    endfunction

    // Mostly well-formed characters; the rest stray bytes, cut and broken sequences.
    task automatic send_random_string();
        int         n;
        int         r;
        logic       cut;
        logic [7:0] lead;
        logic [7:0] c;
        n   = $urandom_range(1, 8);
        cut = 1'b0;
        for (int i = 0; i < n && !cut; i++) begin
            r = $urandom_range(99);
            if (r < 20) begin
                send_byte(8'($urandom_range(1, 127)));
            end else if (r < 40) begin
                send_byte(8'($urandom_range(LEAD_MIN, LEAD2_MAX)));
                send_byte(cont_byte());
            end else if (r < 60) begin
                send_byte(8'($urandom_range(8'hE0, LEAD3_MAX)));
                send_byte(cont_byte());
                send_byte(cont_byte());
            end else if (r < 80) begin
                if ($urandom_range(9) == 0)
                    lead = 8'($urandom_range(8'hF5, 8'hFF));
                else
                    lead = 8'($urandom_range(8'hF0, LEAD4_MAX));
                send_byte(lead);
                c = cont_byte();
                // keep most F4 sequences within range
                if (lead == LEAD4_MAX && $urandom_range(3) != 0)
                    c[5:4] = 2'b00;
                send_byte(c);
                send_byte(cont_byte());
                send_byte(cont_byte());
            end else if (r < 88) begin
                send_byte(8'($urandom_range(1, 255)));
            end else if (r < 96) begin
                send_byte(8'($urandom_range(LEAD_MIN, 255)));
                if ($urandom_range(1) == 1)
                    send_byte(cont_byte());
            end else begin
                send_byte(8'($urandom_range(LEAD_MIN, 255)));
                if ($urandom_range(1) == 1)
                    send_byte(cont_byte());
                cut = 1'b1;
            end
        end
        send_byte(8'h00);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (units.outstanding() != 0)
            @(posedge aclk);
    endtask

    task automatic run_phase(input int idle, input int stall, input int nbytes);
        int start;
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        start          = bytes_sent;
        while (bytes_sent - start < nbytes)
            send_random_string();
        wait_drained();
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (WARMUP[i])
            send_byte(WARMUP[i]);
        wait_drained();

        run_phase(0, 0, 400);
        run_phase(66, 0, 400);
        run_phase(0, 66, 400);
        run_phase(22, 22, 400);

        repeat (16) @(posedge aclk);
        if (units.failures == 0 && units.outstanding() == 0)
            $display("wtf8_to_utf16_decoder_tb OK");
        else
            $display("wtf8_to_utf16_decoder_tb NOT OK");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("wtf8_to_utf16_decoder_tb NOT OK");
        $finish;
    end

endmodule
